### hdl/combined_tausworthe_random_unit_macros.svh
// Assertion macros used by the random unit checker.
`ifndef COMBINED_TAUSWORTHE_RANDOM_UNIT_MACROS_SVH
`define COMBINED_TAUSWORTHE_RANDOM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTAUS_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("random unit check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CTAUS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("random unit check failed");

`endif

### hdl/ctaus_pkg.sv
// Shared types, constants and generator step functions for the random unit.
package ctaus_pkg;

    localparam logic [2:0] OP_RESEED = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_COIN   = 3'd2;
    localparam logic [2:0] OP_ODDS   = 3'd3;
    localparam logic [2:0] OP_RANGE  = 3'd4;

    localparam logic [31:0] MASK_ONE   = 32'hFFFF_FFFE;
    localparam logic [31:0] MASK_TWO   = 32'hFFFF_FFF8;
    localparam logic [31:0] MASK_THREE = 32'hFFFF_FFF0;
    localparam logic [31:0] SALT_ONE   = 32'hFEA0_9B9D;
    localparam logic [31:0] SALT_TWO   = 32'h9C12_9511;
    localparam logic [31:0] SALT_THREE = 32'h2512_CFB8;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    typedef struct packed {
        logic [31:0] one;
        logic [31:0] two;
        logic [31:0] three;
    } comps_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic fin_load;
    } ctaus_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_div;
        logic div_last;
    } ctaus_stat_t;

    function automatic comps_t ctaus_advance(comps_t c);
        comps_t n;
        n.one   = ((c.one & MASK_ONE) << 24) ^ ((c.one ^ (c.one << 7)) >> 7);
        n.two   = ((c.two & MASK_TWO) << 7) ^ ((c.two ^ (c.two << 2)) >> 22);
        n.three = ((c.three & MASK_THREE) << 11) ^ ((c.three ^ (c.three << 9)) >> 17);
        return n;
    endfunction

    function automatic comps_t ctaus_reseed(logic [31:0] s);
        comps_t n;
        n.one   = (s ^ SALT_ONE) & MASK_ONE;
        n.two   = (s ^ SALT_TWO) & MASK_TWO;
        n.three = (s ^ SALT_THREE) & MASK_THREE;
        // fold the top bits of (x << k) ^ x into the low bits
        n.one   = n.one ^ (((n.one << 7) ^ n.one) >> 31);
        n.two   = n.two ^ (((n.two << 2) ^ n.two) >> 29);
        n.three = n.three ^ (((n.three << 9) ^ n.three) >> 28);
        return ctaus_advance(n);
    endfunction

    localparam comps_t COMPS_INIT = ctaus_reseed(32'd0);

endpackage

### hdl/ctaus_ctrl.sv
// Sequencer for the random unit: accept, setup, divide, deliver.
module ctaus_ctrl
    import ctaus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  ctaus_stat_t stat,
    output ctaus_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.prep     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.fin_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.needs_div ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait here while the output register still holds an untaken beat
                if (out_free)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.fin_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/ctaus_dp.sv
// Datapath: generator components, radix-2 remainder unit and output register.
module ctaus_dp
    import ctaus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctaus_cmd_t  cmd,
    output ctaus_stat_t stat,
    input  logic [2:0]  op,
    input  logic [31:0] seed_value,
    input  logic [31:0] arg_a,
    input  logic [31:0] arg_b,
    output logic [31:0] value,
    output logic        decision
);

    comps_t           comp_reg;
    comps_t           comp_adv;
    comps_t           comp_next;
    logic [31:0]      word_reg;
    logic [2:0]       op_reg;
    logic [31:0]      lo_reg, hi_reg, mod_reg, rem_reg, dvd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      value_reg;
    logic             decision_reg;

    logic             swap;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic [31:0]      rem_final;
    logic [31:0]      value_next;
    logic             decision_next;

    assign comp_adv = ctaus_advance(comp_reg);

    always_comb
    begin
        if (op == OP_RESEED)
            comp_next = ctaus_reseed(seed_value);
        else if (op == OP_RAW || op == OP_COIN || op == OP_ODDS || op == OP_RANGE)
            comp_next = comp_adv;
        else
            comp_next = comp_reg;
    end

    // signed compare of the range bounds
    assign swap = (op == OP_RANGE) && ($signed(arg_a) > $signed(arg_b));

    // one restoring step per cycle
    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, mod_reg};

    // zero modulus means 2^32: the word is its own remainder
    assign rem_final = (mod_reg == 32'd0) ? word_reg : rem_reg;

    always_comb
    begin
        value_next    = 32'd0;
        decision_next = 1'b0;
        if (op_reg == OP_RAW)
            value_next = word_reg;
        else if (op_reg == OP_COIN)
            decision_next = word_reg[31];
        else if (op_reg == OP_ODDS)
            decision_next = (rem_final <= hi_reg);
        else if (op_reg == OP_RANGE)
            value_next = rem_final + lo_reg;
    end

    assign stat.needs_div = (op_reg == OP_ODDS) || (op_reg == OP_RANGE);
    assign stat.div_last  = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            comp_reg <= COMPS_INIT;
        else if (cmd.load)
            comp_reg <= comp_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            word_reg <= comp_adv.one ^ comp_adv.two ^ comp_adv.three;
            lo_reg   <= swap ? arg_b : arg_a;
            hi_reg   <= swap ? arg_a : arg_b;
        end
        if (cmd.prep)
        begin
            mod_reg <= (op_reg == OP_ODDS) ? lo_reg + 32'd1 : hi_reg - lo_reg + 32'd1;
            rem_reg <= 32'd0;
            dvd_reg <= word_reg;
            cnt_reg <= CNT_W'(WORD_W - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg <= diff[32] ? trial[31:0] : diff[31:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.fin_load)
        begin
            value_reg    <= value_next;
            decision_reg <= decision_next;
        end
    end

    assign value    = value_reg;
    assign decision = decision_reg;

endmodule

### hdl/combined_tausworthe_random_unit.sv
// Top level of the combined Tausworthe random unit.
// Every accepted beat yields one result beat. Reseed, raw word, coin flip and
// unknown operations pass from acceptance through the setup and finish states
// into the output register; odds and range also pass through the remainder
// unit, which resolves one quotient bit per cycle. One item is worked at a time:
// in_stall stays high from the cycle after acceptance until the result has
// moved into the output register, so the next beat can be taken once it is
// there. The output register can hold a finished beat while the next item is
// accepted.
// The generator state comes out of reset as if reseeded with zero.
module combined_tausworthe_random_unit
    import ctaus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [31:0] seed_value,
    input  logic [31:0] arg_a,
    input  logic [31:0] arg_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        decision
);

    ctaus_cmd_t  cmd;
    ctaus_stat_t stat;

    ctaus_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctaus_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .seed_value (seed_value),
        .arg_a      (arg_a),
        .arg_b      (arg_b),
        .value      (value),
        .decision   (decision)
    );

endmodule

### hdl/ctaus_checker.sv
// Port-level checks for the random unit and their binding to the top level.
`include "combined_tausworthe_random_unit_macros.svh"

module ctaus_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] value,
    input logic        decision
);

    // a stalled result beat holds
    `CTAUS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(decision))

    // one item at a time: busy right after an accepted beat
    `CTAUS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a decision comes only with a zero value
    `CTAUS_ASSERT_NOW(a_value_or_decision, out_valid && decision, value == 32'd0)

    // a new result appears only out of a busy cycle
    `CTAUS_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind combined_tausworthe_random_unit ctaus_checker u_ctaus_checker (.*);

### tb/tb_combined_tausworthe_random_unit.sv
// Self-checking testbench for the combined Tausworthe random unit.
module tb_combined_tausworthe_random_unit
    import ctaus_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 250;

    typedef struct {
        logic [31:0] value;
        logic        decision;
    } draw_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [31:0] seed_value;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;
    logic        decision;

    // generator state as predicted
    logic [31:0] comp_one;
    logic [31:0] comp_two;
    logic [31:0] comp_three;

    draw_t pending_draws[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_left;
    int    quiet_cycles;

    combined_tausworthe_random_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .seed_value (seed_value),
        .arg_a      (arg_a),
        .arg_b      (arg_b),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .decision   (decision)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] step_components();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = ((comp_one & MASK_ONE) << 24) ^ ((comp_one ^ (comp_one << 7)) >> 7);
        b = ((comp_two & MASK_TWO) << 7) ^ ((comp_two ^ (comp_two << 2)) >> 22);
        c = ((comp_three & MASK_THREE) << 11) ^ ((comp_three ^ (comp_three << 9)) >> 17);
        comp_one   = a;
        comp_two   = b;
        comp_three = c;
        return a ^ b ^ c;
    endfunction

    function automatic void seed_components(logic [31:0] seed);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = (seed ^ SALT_ONE) & MASK_ONE;
        b = (seed ^ SALT_TWO) & MASK_TWO;
        c = (seed ^ SALT_THREE) & MASK_THREE;
        // top bits of the shifted xor fold into the low bits
        a = a ^ (((a << 7) ^ a) >> 31);
        b = b ^ (((b << 2) ^ b) >> 29);
        c = c ^ (((c << 9) ^ c) >> 28);
        comp_one   = a;
        comp_two   = b;
        comp_three = c;
        void'(step_components());
    endfunction

    function automatic draw_t predict_draw(logic [2:0] code, logic [31:0] seed,
                                           logic [31:0] first, logic [31:0] second);
        draw_t       d;
        logic [31:0] word;
        logic [31:0] modulus;
        logic [31:0] lo;
        logic [31:0] hi;
        d.value    = 32'd0;
        d.decision = 1'b0;
        case (code)
            OP_RESEED: seed_components(seed);
            OP_RAW:    d.value = step_components();
            OP_COIN:
            begin
                word = step_components();
                d.decision = word[31];
            end
            OP_ODDS:
            begin
                word = step_components();
                modulus = first + 32'd1;
                // zero modulus means 2^32: the raw word is the remainder
                d.decision = (((modulus == 32'd0) ? word : word % modulus) <= second);
            end
            OP_RANGE:
            begin
                lo = first;
                hi = second;
                if ($signed(first) > $signed(second))
                begin
                    lo = second;
                    hi = first;
                end
                word = step_components();
                modulus = hi - lo + 32'd1;
                d.value = ((modulus == 32'd0) ? word : word % modulus) + lo;
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Drives one beat from the falling edge and returns at the edge that takes it.
    task automatic send_item(logic [2:0] code, logic [31:0] seed,
                             logic [31:0] first, logic [31:0] second);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        op         = code;
        seed_value = seed;
        arg_a      = first;
        arg_b      = second;
        do
            @(posedge clk);
        while (in_stall);
        pending_draws.push_back(predict_draw(code, seed, first, second));
    endtask

    task automatic send_random_item();
        logic [2:0]  code;
        logic [31:0] seed;
        logic [31:0] first;
        logic [31:0] second;
        int          pick;
        pick   = $urandom_range(99);
        seed   = $urandom;
        first  = $urandom;
        second = $urandom;
        if (pick < 5)
            code = OP_RESEED;
        else if (pick < 20)
            code = OP_RAW;
        else if (pick < 35)
            code = OP_COIN;
        else if (pick < 65)
            code = OP_ODDS;
        else if (pick < 95)
            code = OP_RANGE;
        else
            code = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        if (code == OP_ODDS)
        begin
            case ($urandom_range(3))
                0:
                begin
                    first  = $urandom_range(64);
                    second = $urandom_range(64);
                end
                1: first = 32'hFFFF_FFFF;
                2: second = $urandom_range(first);
                default: ;
            endcase
        end
        else if (code == OP_RANGE)
        begin
            case ($urandom_range(3))
                0: second = first + $urandom_range(255);
                1:
                begin
                    first  = $urandom_range(200) - 100;
                    second = $urandom_range(200) - 100;
                end
                2: second = first - $urandom_range(1000);
                default: ;
            endcase
        end
        send_item(code, seed, first, second);
    endtask

    task automatic test_reset_state();
        send_item(OP_RAW, $urandom, $urandom, $urandom);
        send_item(OP_RAW, $urandom, $urandom, $urandom);
    endtask

    task automatic test_reseed();
        send_item(OP_RESEED, 32'h0000_0000, $urandom, $urandom);
        send_item(OP_RAW, 32'h0, 32'h0, 32'h0);
        send_item(OP_RESEED, 32'hFFFF_FFFF, $urandom, $urandom);
        send_item(OP_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_RESEED, $urandom, $urandom, $urandom);
        send_item(OP_RAW, $urandom, $urandom, $urandom);
    endtask

    task automatic test_coin();
        repeat (3)
            send_item(OP_COIN, $urandom, $urandom, $urandom);
    endtask

    task automatic test_odds();
        send_item(OP_ODDS, $urandom, 32'hFFFF_FFFF, 32'h0000_0000);   // zero modulus
        send_item(OP_ODDS, $urandom, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(OP_ODDS, $urandom, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_ODDS, $urandom, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(OP_ODDS, $urandom, $urandom, 32'h0000_0000);
    endtask

    task automatic test_range();
        send_item(OP_RANGE, $urandom, 32'd10, 32'd20);
        send_item(OP_RANGE, $urandom, 32'd20, 32'd10);                 // reversed
        send_item(OP_RANGE, $urandom, 32'hFFFF_FFF6, 32'hFFFF_FFF6);   // single value
        send_item(OP_RANGE, $urandom, 32'h8000_0000, 32'h7FFF_FFFF);   // full span wraps to 0
        send_item(OP_RANGE, $urandom, 32'h7FFF_FFFF, 32'h8000_0000);   // reversed extremes
        send_item(OP_RANGE, $urandom, 32'h0000_0000, 32'hFFFF_FFFF);   // -1 below 0
    endtask

    task automatic test_unknown_ops();
        send_item(OP_UNUSED_FIRST, $urandom, $urandom, $urandom);
        send_item(OP_UNUSED_MID, $urandom, $urandom, $urandom);
        send_item(OP_UNUSED_LAST, $urandom, $urandom, $urandom);
        send_item(OP_RAW, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            send_random_item();
    endtask

    // Receiver holds off while items keep coming, so the unit fills and stalls.
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        repeat (8)
            send_random_item();
    endtask

    task automatic finish_run();
        @(negedge clk);
        in_valid = 1'b0;
        recv_stall_pct = 0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS combined_tausworthe_random_unit");
        else
            $display("FAIL combined_tausworthe_random_unit");
        $finish;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_RAW;
        seed_value     = 32'd0;
        arg_a          = 32'd0;
        arg_b          = 32'd0;
        out_stall      = 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        seed_components(32'd0);
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_reseed();
        test_coin();
        test_odds();
        test_range();
        test_unknown_ops();
        test_random_phase(0, 0);
        test_random_phase(50, 0);
        test_output_hold();
        test_random_phase(0, 50);
        test_random_phase(25, 25);
        finish_run();
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
                report_mismatch("unexpected beat value", value, 32'd0);
            else
            begin
                want = pending_draws.pop_front();
                if (value !== want.value)
                    report_mismatch("value", value, want.value);
                if (decision !== want.decision)
                    report_mismatch("decision", 32'(decision), 32'(want.decision));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("FAIL combined_tausworthe_random_unit");
                $finish;
            end
        end
    end

endmodule

### combined_tausworthe_random_unit.f
+incdir+hdl
hdl/ctaus_pkg.sv
hdl/ctaus_ctrl.sv
hdl/ctaus_dp.sv
hdl/combined_tausworthe_random_unit.sv
hdl/ctaus_checker.sv
tb/tb_combined_tausworthe_random_unit.sv
